>>> src/cau_pkg.sv
// ----------------------------------------------------------------------------
// cau_pkg
// Shared types and constants for the complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

    localparam int DATA_W      = 32;
    localparam int FRAC_DEF    = 16;
    localparam int QDEPTH_DEF  = 4;

    localparam logic [DATA_W-1:0] RES_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] RES_MIN = 32'h8000_0000;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } cau_op_t;

    // classified word handed from the front end to the back end
    typedef struct packed {
        cau_op_t                   op;
        logic                      dz;
        logic signed [DATA_W-1:0]  a_re;
        logic signed [DATA_W-1:0]  a_im;
        logic signed [DATA_W-1:0]  b_re;
        logic signed [DATA_W-1:0]  b_im;
    } cau_item_t;

    typedef struct packed {
        logic [DATA_W-1:0] val;
        logic              sat;
    } cau_sat_t;

endpackage

>>> src/cau_in_if.sv
// ----------------------------------------------------------------------------
// cau_in_if
// Operand channel: operation code and two complex operands.
// ----------------------------------------------------------------------------
interface cau_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         operation;
    logic signed [31:0] a_re;
    logic signed [31:0] a_im;
    logic signed [31:0] b_re;
    logic signed [31:0] b_im;

    modport source (output valid, output operation, output a_re, output a_im,
                    output b_re, output b_im, input ready);
    modport sink   (input valid, input operation, input a_re, input a_im,
                    input b_re, input b_im, output ready);
endinterface

>>> src/cau_out_if.sv
// ----------------------------------------------------------------------------
// cau_out_if
// Result channel: complex result and status flags.
// ----------------------------------------------------------------------------
interface cau_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] res_re;
    logic signed [31:0] res_im;
    logic               saturated;
    logic               div_by_zero;

    modport source (output valid, output res_re, output res_im, output saturated,
                    output div_by_zero, input ready);
    modport sink   (input valid, input res_re, input res_im, input saturated,
                    input div_by_zero, output ready);
endinterface

>>> src/cau_front.sv
// ----------------------------------------------------------------------------
// cau_front
// Accepts operand words, decodes the operation and flags a zero divisor.
// ----------------------------------------------------------------------------
module cau_front
    import cau_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    cau_in_if.sink    in_ch,
    output cau_item_t item,
    output logic      item_valid,
    input  logic      item_ready
);

    logic      vld_reg;
    logic      vld_next;
    cau_item_t item_reg;
    cau_item_t item_next;
    logic      take;

    assign in_ch.ready = !vld_reg || item_ready;
    assign take        = in_ch.valid && in_ch.ready;

    always_comb
    begin
        item_next.op   = cau_op_t'(in_ch.operation);
        item_next.a_re = in_ch.a_re;
        item_next.a_im = in_ch.a_im;
        item_next.b_re = in_ch.b_re;
        item_next.b_im = in_ch.b_im;
        item_next.dz   = (cau_op_t'(in_ch.operation) == OP_DIV)
                         && (in_ch.b_re == '0) && (in_ch.b_im == '0);
    end

    always_comb
    begin
        if (take)
            vld_next = 1'b1;
        else if (item_ready)
            vld_next = 1'b0;
        else
            vld_next = vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            item_reg <= item_next;
    end

    assign item       = item_reg;
    assign item_valid = vld_reg;

endmodule

>>> src/cau_queue.sv
// ----------------------------------------------------------------------------
// cau_queue
// Short FIFO between the front end and the arithmetic back end.
// ----------------------------------------------------------------------------
module cau_queue
    import cau_pkg::*;
#(
    parameter int DEPTH = QDEPTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  cau_item_t push_item,
    input  logic      push_valid,
    output logic      push_ready,
    output cau_item_t pop_item,
    output logic      pop_valid,
    input  logic      pop_ready
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    cau_item_t       slot_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg;
    logic [PW-1:0]   rd_ptr_next;
    logic [NW-1:0]   count_reg;
    logic [NW-1:0]   count_next;
    logic            push;
    logic            pop;

    assign push_ready = (count_reg != NW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_item;
    end

endmodule

>>> src/cau_back.sv
// ----------------------------------------------------------------------------
// cau_back
// Arithmetic pipeline: products, sums, rounding, a 32-stage restoring
// divider, saturation and the output register. The whole pipe moves as one
// when the output register is free.
// ----------------------------------------------------------------------------
module cau_back
    import cau_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  cau_item_t item,
    input  logic      item_valid,
    output logic      item_ready,
    cau_out_if.source out_ch
);

    localparam int QB = DATA_W;
    localparam int CW = (64 + FRAC_BITS > 96) ? 64 + FRAC_BITS : 96;
    localparam int NV = 3 + QB + 1;

    typedef struct packed {
        logic              div;
        logic              dz;
        logic              neg_re;
        logic              neg_im;
        logic              ovf_re;
        logic              ovf_im;
        logic [63:0]       rem_re;
        logic [63:0]       rem_im;
        logic [QB-1:0]     num_re;
        logic [QB-1:0]     num_im;
        logic [QB-1:0]     q_re;
        logic [QB-1:0]     q_im;
        logic [63:0]       den;
        logic [QB-1:0]     val_re;
        logic [QB-1:0]     val_im;
        logic              sat;
    } cau_dv_t;

    function automatic cau_sat_t sat65(input logic signed [64:0] v);
        cau_sat_t r;
        if ((&v[64:DATA_W-1]) || !(|v[64:DATA_W-1]))
        begin
            r.val = v[DATA_W-1:0];
            r.sat = 1'b0;
        end
        else
        begin
            r.val = v[64] ? RES_MIN : RES_MAX;
            r.sat = 1'b1;
        end
        return r;
    endfunction

    function automatic cau_dv_t div_step(input cau_dv_t d);
        cau_dv_t     r;
        logic [64:0] t_re;
        logic [64:0] t_im;
        r    = d;
        t_re = {d.rem_re, d.num_re[QB-1]};
        t_im = {d.rem_im, d.num_im[QB-1]};
        if (t_re >= {1'b0, d.den})
        begin
            r.rem_re = 64'(t_re - {1'b0, d.den});
            r.q_re   = {d.q_re[QB-2:0], 1'b1};
        end
        else
        begin
            r.rem_re = t_re[63:0];
            r.q_re   = {d.q_re[QB-2:0], 1'b0};
        end
        if (t_im >= {1'b0, d.den})
        begin
            r.rem_im = 64'(t_im - {1'b0, d.den});
            r.q_im   = {d.q_im[QB-2:0], 1'b1};
        end
        else
        begin
            r.rem_im = t_im[63:0];
            r.q_im   = {d.q_im[QB-2:0], 1'b0};
        end
        r.num_re = {d.num_re[QB-2:0], 1'b0};
        r.num_im = {d.num_im[QB-2:0], 1'b0};
        return r;
    endfunction

    function automatic cau_sat_t div_fin(input logic neg, input logic ovf,
                                         input logic [QB-1:0] q);
        cau_sat_t r;
        if (ovf)
        begin
            r.val = neg ? RES_MIN : RES_MAX;
            r.sat = 1'b1;
        end
        else if (neg)
        begin
            if (q > RES_MIN)
            begin
                r.val = RES_MIN;
                r.sat = 1'b1;
            end
            else
            begin
                r.val = '0 - q;
                r.sat = 1'b0;
            end
        end
        else if (q[QB-1])
        begin
            r.val = RES_MAX;
            r.sat = 1'b1;
        end
        else
        begin
            r.val = q;
            r.sat = 1'b0;
        end
        return r;
    endfunction

    logic                  advance;
    logic [NV-1:0]         vld_reg;
    logic [NV-1:0]         vld_next;

    // product stage
    cau_op_t               s1_op_reg;
    logic                  s1_dz_reg;
    logic signed [63:0]    p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg;
    logic signed [63:0]    d_rr_reg, d_ii_reg;
    logic signed [32:0]    as_re_reg, as_im_reg;
    logic signed [63:0]    p_rr_next, p_ii_next, p_ri_next, p_ir_next;
    logic signed [63:0]    d_rr_next, d_ii_next;
    logic signed [32:0]    as_re_next, as_im_next;

    // sum stage
    cau_op_t               s2_op_reg;
    logic                  s2_dz_reg;
    logic signed [64:0]    s2_re_reg, s2_im_reg;
    logic [63:0]           s2_den_reg;
    logic signed [64:0]    s2_re_next, s2_im_next;
    logic [63:0]           s2_den_next;

    // rounding / magnitude stage
    cau_op_t               s3_op_reg;
    logic                  s3_dz_reg;
    logic signed [64:0]    s3_re_reg, s3_im_reg;
    logic                  s3_neg_re_reg, s3_neg_im_reg;
    logic [63:0]           s3_den_reg;
    logic signed [64:0]    s3_re_next, s3_im_next;
    logic signed [64:0]    bias;

    cau_dv_t               dv_reg [QB+1];
    cau_dv_t               dv0_next;

    logic                  out_vld_reg;
    logic [DATA_W-1:0]     res_re_reg, res_im_reg;
    logic                  sat_reg, dz_reg;
    cau_sat_t              fin_re, fin_im;

    assign advance    = !out_vld_reg || out_ch.ready;
    assign item_ready = advance;
    assign vld_next   = {vld_reg[NV-2:0], item_valid};
    assign bias       = (65'sd1 <<< FRAC_BITS) - 65'sd1;

    always_comb
    begin
        p_rr_next = 64'(item.a_re) * 64'(item.b_re);
        p_ii_next = 64'(item.a_im) * 64'(item.b_im);
        p_ri_next = 64'(item.a_re) * 64'(item.b_im);
        p_ir_next = 64'(item.a_im) * 64'(item.b_re);
        d_rr_next = 64'(item.b_re) * 64'(item.b_re);
        d_ii_next = 64'(item.b_im) * 64'(item.b_im);
        if (item.op == OP_SUB)
        begin
            as_re_next = 33'(item.a_re) - 33'(item.b_re);
            as_im_next = 33'(item.a_im) - 33'(item.b_im);
        end
        else
        begin
            as_re_next = 33'(item.a_re) + 33'(item.b_re);
            as_im_next = 33'(item.a_im) + 33'(item.b_im);
        end
    end

    always_comb
    begin
        s2_den_next = 64'(d_rr_reg) + 64'(d_ii_reg);
        case (s1_op_reg)
            OP_MUL:
            begin
                s2_re_next = 65'(p_rr_reg) - 65'(p_ii_reg);
                s2_im_next = 65'(p_ri_reg) + 65'(p_ir_reg);
            end
            OP_DIV:
            begin
                s2_re_next = 65'(p_rr_reg) + 65'(p_ii_reg);
                s2_im_next = 65'(p_ir_reg) - 65'(p_ri_reg);
            end
            default:
            begin
                s2_re_next = 65'(as_re_reg);
                s2_im_next = 65'(as_im_reg);
            end
        endcase
    end

    // products round toward zero; quotients work on magnitudes
    always_comb
    begin
        case (s2_op_reg)
            OP_MUL:
            begin
                s3_re_next = (s2_re_reg + (s2_re_reg[64] ? bias : 65'sd0)) >>> FRAC_BITS;
                s3_im_next = (s2_im_reg + (s2_im_reg[64] ? bias : 65'sd0)) >>> FRAC_BITS;
            end
            OP_DIV:
            begin
                s3_re_next = s2_re_reg[64] ? -s2_re_reg : s2_re_reg;
                s3_im_next = s2_im_reg[64] ? -s2_im_reg : s2_im_reg;
            end
            default:
            begin
                s3_re_next = s2_re_reg;
                s3_im_next = s2_im_reg;
            end
        endcase
    end

    always_comb
    begin
        cau_sat_t     sr;
        cau_sat_t     si;
        logic [CW-1:0] nw_re;
        logic [CW-1:0] nw_im;
        logic [CW-1:0] dw;
        sr    = sat65(s3_re_reg);
        si    = sat65(s3_im_reg);
        nw_re = CW'(s3_re_reg[63:0]) << FRAC_BITS;
        nw_im = CW'(s3_im_reg[63:0]) << FRAC_BITS;
        dw    = CW'(s3_den_reg) << QB;
        dv0_next.div    = (s3_op_reg == OP_DIV);
        dv0_next.dz     = s3_dz_reg;
        dv0_next.neg_re = s3_neg_re_reg;
        dv0_next.neg_im = s3_neg_im_reg;
        dv0_next.ovf_re = (nw_re >= dw);
        dv0_next.ovf_im = (nw_im >= dw);
        dv0_next.rem_re = 64'(nw_re >> QB);
        dv0_next.rem_im = 64'(nw_im >> QB);
        dv0_next.num_re = nw_re[QB-1:0];
        dv0_next.num_im = nw_im[QB-1:0];
        dv0_next.q_re   = '0;
        dv0_next.q_im   = '0;
        dv0_next.den    = s3_den_reg;
        dv0_next.val_re = sr.val;
        dv0_next.val_im = si.val;
        dv0_next.sat    = sr.sat || si.sat;
    end

    assign fin_re = div_fin(dv_reg[QB].neg_re, dv_reg[QB].ovf_re, dv_reg[QB].q_re);
    assign fin_im = div_fin(dv_reg[QB].neg_im, dv_reg[QB].ovf_im, dv_reg[QB].q_im);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            vld_reg     <= vld_next;
            out_vld_reg <= vld_reg[NV-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_op_reg     <= item.op;
            s1_dz_reg     <= item.dz;
            p_rr_reg      <= p_rr_next;
            p_ii_reg      <= p_ii_next;
            p_ri_reg      <= p_ri_next;
            p_ir_reg      <= p_ir_next;
            d_rr_reg      <= d_rr_next;
            d_ii_reg      <= d_ii_next;
            as_re_reg     <= as_re_next;
            as_im_reg     <= as_im_next;

            s2_op_reg     <= s1_op_reg;
            s2_dz_reg     <= s1_dz_reg;
            s2_re_reg     <= s2_re_next;
            s2_im_reg     <= s2_im_next;
            s2_den_reg    <= s2_den_next;

            s3_op_reg     <= s2_op_reg;
            s3_dz_reg     <= s2_dz_reg;
            s3_re_reg     <= s3_re_next;
            s3_im_reg     <= s3_im_next;
            s3_neg_re_reg <= s2_re_reg[64];
            s3_neg_im_reg <= s2_im_reg[64];
            s3_den_reg    <= s2_den_reg;

            dv_reg[0]     <= dv0_next;

            if (!dv_reg[QB].div)
            begin
                res_re_reg <= dv_reg[QB].val_re;
                res_im_reg <= dv_reg[QB].val_im;
                sat_reg    <= dv_reg[QB].sat;
                dz_reg     <= 1'b0;
            end
            else if (dv_reg[QB].dz)
            begin
                res_re_reg <= '0;
                res_im_reg <= '0;
                sat_reg    <= 1'b0;
                dz_reg     <= 1'b1;
            end
            else
            begin
                res_re_reg <= fin_re.val;
                res_im_reg <= fin_im.val;
                sat_reg    <= fin_re.sat || fin_im.sat;
                dz_reg     <= 1'b0;
            end
        end
    end

    // one quotient bit per stage for both parts
    for (genvar k = 0; k < QB; k++)
    begin : g_div
        always_ff @(posedge clk)
        begin
            if (advance)
                dv_reg[k+1] <= div_step(dv_reg[k]);
        end
    end

    assign out_ch.valid       = out_vld_reg;
    assign out_ch.res_re      = res_re_reg;
    assign out_ch.res_im      = res_im_reg;
    assign out_ch.saturated   = sat_reg;
    assign out_ch.div_by_zero = dz_reg;

endmodule

>>> src/complex_arith_unit.sv
// ----------------------------------------------------------------------------
// complex_arith_unit
// Complex add, subtract, multiply and divide on signed fixed-point operands
// with saturation and divide-by-zero flagging.
//
//   channel   dir   words carried
//   in_ch     in    operation, a_re, a_im, b_re, b_im
//   out_ch    out   res_re, res_im, saturated, div_by_zero
//
// One word per cycle sustained while out_ch is not stalled; every operation
// passes the 32-stage restoring divider. Front register and queue decouple
// in_ch from the pipe; the pipe holds as a whole while out_ch is stalled
// and its output register is full.
// rst_n clears all valid state at once; no clearing pass.
// ----------------------------------------------------------------------------
module complex_arith_unit
    import cau_pkg::*;
#(
    parameter int FRAC_BITS   = FRAC_DEF,
    parameter int QUEUE_DEPTH = QDEPTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    cau_in_if.sink    in_ch,
    cau_out_if.source out_ch
);

    cau_item_t front_item;
    logic      front_valid;
    logic      front_ready;
    cau_item_t back_item;
    logic      back_valid;
    logic      back_ready;

    cau_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .item       (front_item),
        .item_valid (front_valid),
        .item_ready (front_ready)
    );

    cau_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_item  (front_item),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .pop_item   (back_item),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready)
    );

    cau_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (back_item),
        .item_valid (back_valid),
        .item_ready (back_ready),
        .out_ch     (out_ch)
    );

    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.div_by_zero |->
            out_ch.res_re == '0 && out_ch.res_im == '0 && !out_ch.saturated)
        else $error("divide by zero word carries a non-zero result");

    a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.saturated |->
            out_ch.res_re == RES_MAX || out_ch.res_re == RES_MIN ||
            out_ch.res_im == RES_MAX || out_ch.res_im == RES_MIN)
        else $error("saturation flagged without a clipped part");

    a_full_queue: assert property (@(posedge clk) disable iff (!rst_n)
        !front_ready |-> back_valid)
        else $error("queue refuses words while empty");

endmodule
